// ===== src/aqe_pkg.sv =====
// ----------------------------------------------------------------------------
// aqe_pkg
// shared constants, operation and status codes, and the command and status
// bundles that join the controller and the datapath of the query engine
// ----------------------------------------------------------------------------
`default_nettype none

package aqe_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int ST_W  = 2;
  localparam int RK_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
  localparam logic [OP_W-1:0] OP_RANGE  = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // kinds of result the datapath can load into its output register
  localparam logic [RK_W-1:0] RK_FULL  = 3'd0;
  localparam logic [RK_W-1:0] RK_BAD   = 3'd1;
  localparam logic [RK_W-1:0] RK_EMPTY = 3'd2;
  localparam logic [RK_W-1:0] RK_DATA  = 3'd3;
  localparam logic [RK_W-1:0] RK_HIT   = 3'd4;
  localparam logic [RK_W-1:0] RK_MISS  = 3'd5;

  typedef struct packed {
    logic            capture;    // latch the input item
    logic            append_wr;  // write value at fill count, bump count
    logic            idx_zero;   // walk index to first entry
    logic            idx_start;  // walk index to range start
    logic            idx_inc;    // advance walk index
    logic            rd_en;      // read store at walk index
    logic            out_load;   // load output register
    logic [RK_W-1:0] kind;       // what to load
  } aqe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty_rng;
    logic            bad_rng;
    logic            fill_zero;
    logic            match;
    logic            idx_at_end;
    logic            idx_last;
    logic            out_free;
  } aqe_sts_t;

endpackage

`default_nettype wire

// ===== src/array_query_engine_unit.sv =====
// ----------------------------------------------------------------------------
// array_query_engine_unit
// store of signed values answering append, read, find and range items
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries operation, value, position and
//   end_position; result channel out_valid/out_ready carries data,
//   found_position, status and last. one item is handled at a time.
//   what each operation does after the input transfer:
//     append        writes the value at the fill count; no result unless full
//     read          one result; the store read is registered
//     status result loaded at decode (out of range, empty range, full, empty find)
//     find          walks from the first entry until a match or the fill count
//     range         one result per entry from position to end_position
//   the next item can be taken in the cycle after the last result is loaded.
//   each stored entry walked takes a read of the store read port, then a
//   compare or a load of the output register.
//   a result sits in an output register, so the next item is taken while
//   the last result of the previous one still waits for its transfer.
//   a stalled receiver holds the walk in place; nothing is dropped.
//   reset clears the fill count, the controller and the output valid; the
//   store contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module array_query_engine_unit #(
  parameter int DEPTH      = aqe_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aqe_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [aqe_pkg::OP_W-1:0]      in_operation,
  input  wire signed [DATA_WIDTH-1:0]  in_value,
  input  wire [aqe_pkg::POS_W-1:0]     in_position,
  input  wire [aqe_pkg::POS_W-1:0]     in_end_position,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [DATA_WIDTH-1:0] out_data,
  output logic [aqe_pkg::POS_W-1:0]    out_found_position,
  output logic [aqe_pkg::ST_W-1:0]     out_status,
  output logic                         out_last
);

  // command and status between controller and datapath
  aqe_pkg::aqe_cmd_t cmd;
  aqe_pkg::aqe_sts_t sts;

  // controller: decode, walk sequencing, output load timing
  aqe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: store, fill count, walk index, output register
  aqe_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .in_position        (in_position),
    .in_end_position    (in_end_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .out_found_position (out_found_position),
    .out_status         (out_status),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== src/aqe_datapath.sv =====
// ----------------------------------------------------------------------------
// aqe_datapath
// element store, fill count, walk index, item registers and output register
// ----------------------------------------------------------------------------
`default_nettype none

module aqe_datapath #(
  parameter int DEPTH      = aqe_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aqe_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  aqe_pkg::aqe_cmd_t            cmd,
  output aqe_pkg::aqe_sts_t            sts,
  input  wire [aqe_pkg::OP_W-1:0]      in_operation,
  input  wire signed [DATA_WIDTH-1:0]  in_value,
  input  wire [aqe_pkg::POS_W-1:0]     in_position,
  input  wire [aqe_pkg::POS_W-1:0]     in_end_position,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [DATA_WIDTH-1:0] out_data,
  output logic [aqe_pkg::POS_W-1:0]    out_found_position,
  output logic [aqe_pkg::ST_W-1:0]     out_status,
  output logic                         out_last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = aqe_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] q_r;

  logic [aqe_pkg::OP_W-1:0] op_r;
  logic [DATA_WIDTH-1:0]    val_r;
  logic [POS_W-1:0]         pos_r;
  logic [POS_W-1:0]         endp_r;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0]        out_data_r, out_data_nxt;
  logic [POS_W-1:0]             out_pos_r, out_pos_nxt;
  logic [aqe_pkg::ST_W-1:0]     out_st_r, out_st_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [POS_W-1:0] fill_ext;
  logic [POS_W-1:0] idx_pos;  // 1-based position of walk index

  assign fill_ext = POS_W'(fill_r);
  assign idx_pos  = POS_W'(idx_r) + POS_W'(1);

  // item registers; a read is a range of one entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      val_r  <= in_value;
      pos_r  <= in_position;
      endp_r <= (in_operation == aqe_pkg::OP_READ) ? in_position : in_end_position;
    end
  end

  // store, registered read port
  always_ff @(posedge clk) begin
    if (cmd.append_wr) begin
      mem[fill_r[IDX_W-1:0]] <= val_r;
    end
    if (cmd.rd_en) begin
      q_r <= mem[idx_r];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.append_wr) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_start) begin
      idx_nxt = IDX_W'(pos_r - POS_W'(1));
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
    idx_r <= idx_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_pos_nxt   = out_pos_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_pos_nxt   = '0;
      out_st_nxt    = aqe_pkg::ST_OK;
      out_last_nxt  = 1'b1;
      case (cmd.kind)
        aqe_pkg::RK_FULL:  out_st_nxt = aqe_pkg::ST_FULL;
        aqe_pkg::RK_BAD:   out_st_nxt = aqe_pkg::ST_RANGE;
        aqe_pkg::RK_EMPTY: out_st_nxt = aqe_pkg::ST_EMPTY;
        aqe_pkg::RK_DATA: begin
          out_data_nxt = q_r;
          out_last_nxt = (idx_pos == endp_r);
        end
        aqe_pkg::RK_HIT:   out_pos_nxt = idx_pos;
        default:           out_pos_nxt = '0;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_pos_r  <= out_pos_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign out_found_position = out_pos_r;
  assign out_status         = out_st_r;
  assign out_last           = out_last_r;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.full       = (fill_r == CNT_W'(DEPTH));
    sts.empty_rng  = (pos_r > endp_r);
    sts.bad_rng    = (pos_r == '0) || (endp_r > fill_ext);
    sts.fill_zero  = (fill_r == '0);
    sts.match      = (q_r == val_r);
    sts.idx_at_end = (idx_pos == fill_ext);
    sts.idx_last   = (idx_pos == endp_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append_wr |-> !sts.full)
    else $error("append written into a full store");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before transfer");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append_wr |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("fill count did not advance on append");

endmodule

`default_nettype wire

// ===== src/aqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// aqe_ctrl
// controller state machine: decodes the held item and sequences the store walk
// ----------------------------------------------------------------------------
`default_nettype none

module aqe_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  aqe_pkg::aqe_sts_t   sts,
  output aqe_pkg::aqe_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_FIND_RD  = 3'd2;
  localparam logic [2:0] S_FIND_CMP = 3'd3;
  localparam logic [2:0] S_RNG_RD   = 3'd4;
  localparam logic [2:0] S_RNG_LD   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.kind  = aqe_pkg::RK_MISS;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          aqe_pkg::OP_APPEND: begin
            if (!sts.full) begin
              cmd.append_wr = 1'b1;
              state_nxt     = S_IDLE;
            end else if (sts.out_free) begin
              cmd.out_load = 1'b1;
              cmd.kind     = aqe_pkg::RK_FULL;
              state_nxt    = S_IDLE;
            end
          end
          aqe_pkg::OP_FIND: begin
            if (!sts.fill_zero) begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_FIND_RD;
            end else if (sts.out_free) begin
              cmd.out_load = 1'b1;
              cmd.kind     = aqe_pkg::RK_MISS;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            // read and range
            if (sts.empty_rng) begin
              if (sts.out_free) begin
                cmd.out_load = 1'b1;
                cmd.kind     = aqe_pkg::RK_EMPTY;
                state_nxt    = S_IDLE;
              end
            end else if (sts.bad_rng) begin
              if (sts.out_free) begin
                cmd.out_load = 1'b1;
                cmd.kind     = aqe_pkg::RK_BAD;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.idx_start = 1'b1;
              state_nxt     = S_RNG_RD;
            end
          end
        endcase
      end
      S_FIND_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.kind     = aqe_pkg::RK_HIT;
            state_nxt    = S_IDLE;
          end
        end else if (sts.idx_at_end) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.kind     = aqe_pkg::RK_MISS;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FIND_RD;
        end
      end
      S_RNG_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RNG_LD;
      end
      S_RNG_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = aqe_pkg::RK_DATA;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RNG_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DECODE)
    else $error("captured item not decoded next cycle");

  a_read_then_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> (state_r == S_FIND_CMP || state_r == S_RNG_LD))
    else $error("store read not followed by its use");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.idx_inc) |-> !in_ready)
    else $error("input ready during a store walk");

endmodule

`default_nettype wire
